@@ design/rdc_pkg.sv @@
`default_nettype none

package rdc_pkg;

   // Fixed field widths of the request and response transfers.
   localparam int POS_W   = 15;
   localparam int VALUE_W = 20;
   localparam int COUNT_W = 16;

   // Defaults for the top-level parameters.
   localparam int DEF_MAX_ELEMENTS = 32768;
   localparam int DEF_VALUE_SPACE  = 1048576;

   // Request command codes.
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Operation codes of a queued entry, set by the front end.
   localparam int         OP_W     = 2;
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_QUERY = 2'd1;
   localparam logic [1:0] OP_ERROR = 2'd2;

   // Queue between front end and back end.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic               cmd;
      logic [POS_W-1:0]   position;
      logic [VALUE_W-1:0] element_value;
      logic [POS_W-1:0]   range_left;
      logic [POS_W-1:0]   range_right;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] distinct_count;
      logic               range_error;
   } rsp_type;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [POS_W-1:0]   position;
      logic [VALUE_W-1:0] element_value;
      logic [POS_W-1:0]   range_left;
      logic [POS_W-1:0]   range_right;
   } entry_type;

   typedef struct packed {
      logic valid;
      logic full;
   } q_stat_type;

endpackage

`default_nettype wire

@@ design/rdc_front.sv @@
`default_nettype none

// Classifies a request into a queue entry and drops writes that fall outside
// the element store or the value space.
module rdc_front #(
   parameter int MAX_ELEMENTS = rdc_pkg::DEF_MAX_ELEMENTS,
   parameter int VALUE_SPACE  = rdc_pkg::DEF_VALUE_SPACE
) (
   input  rdc_pkg::req_type   req,
   output rdc_pkg::entry_type entry,
   output logic               keep
);

   localparam int IDX_W = $clog2(MAX_ELEMENTS);
   localparam int VAL_W = $clog2(VALUE_SPACE);
   localparam int PW    = IDX_W + rdc_pkg::POS_W;
   localparam int VW    = VAL_W + rdc_pkg::VALUE_W;

   logic [PW-1:0] pos_wide;
   logic [PW-1:0] right_wide;
   logic [VW-1:0] val_wide;
   logic          write_ok;
   logic          range_bad;

   assign pos_wide   = {{IDX_W{1'b0}}, req.position};
   assign right_wide = {{IDX_W{1'b0}}, req.range_right};
   assign val_wide   = {{VAL_W{1'b0}}, req.element_value};

   assign write_ok  = (pos_wide < PW'(MAX_ELEMENTS)) && (val_wide < VW'(VALUE_SPACE));
   assign range_bad = (req.range_left > req.range_right) ||
                      (right_wide >= PW'(MAX_ELEMENTS));

   always_comb begin
      entry.position      = req.position;
      entry.element_value = req.element_value;
      entry.range_left    = req.range_left;
      entry.range_right   = req.range_right;
      if (req.cmd == rdc_pkg::CMD_QUERY) begin
         entry.op = range_bad ? rdc_pkg::OP_ERROR : rdc_pkg::OP_QUERY;
         keep     = 1'b1;
      end else begin
         entry.op = rdc_pkg::OP_WRITE;
         keep     = write_ok;
      end
   end

endmodule

`default_nettype wire

@@ design/rdc_queue.sv @@
`default_nettype none

// Small FIFO of classified entries between the front end and the back end.
module rdc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rdc_pkg::entry_type  push_entry,
   input  logic                pop,
   output rdc_pkg::entry_type  head,
   output rdc_pkg::q_stat_type stat
);

   rdc_pkg::entry_type entries_ff [rdc_pkg::QUEUE_DEPTH];

   logic [rdc_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [rdc_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [rdc_pkg::QCNT_W-1:0] count_ff, count_in;

   localparam logic [rdc_pkg::QPTR_W-1:0] PTR_LAST = rdc_pkg::QPTR_W'(rdc_pkg::QUEUE_DEPTH - 1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head       = entries_ff[rd_ptr_ff];
   assign stat.valid = (count_ff != '0);
   assign stat.full  = (count_ff == rdc_pkg::QCNT_W'(rdc_pkg::QUEUE_DEPTH));

endmodule

`default_nettype wire

@@ design/rdc_back.sv @@
`default_nettype none

// Window engine: owns the element store, the occurrence counters and the
// sliding window, and carries out one queued entry at a time.
module rdc_back #(
   parameter int MAX_ELEMENTS = rdc_pkg::DEF_MAX_ELEMENTS,
   parameter int VALUE_SPACE  = rdc_pkg::DEF_VALUE_SPACE
) (
   input  logic               clock,
   input  logic               reset,
   input  rdc_pkg::entry_type head,
   input  logic               head_valid,
   output logic               pop,
   output logic               clearing,
   output logic               rsp_valid,
   output rdc_pkg::rsp_type   rsp_data
);

   localparam int IDX_W = $clog2(MAX_ELEMENTS);
   localparam int VAL_W = $clog2(VALUE_SPACE);
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
   localparam int POS_W = rdc_pkg::POS_W;
   localparam int VIN_W = rdc_pkg::VALUE_W;

   localparam logic [VAL_W-1:0] VAL_LAST = VAL_W'(VALUE_SPACE - 1);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_PLAN   = 3'd2;
   localparam logic [2:0] ST_CNT_RD = 3'd3;
   localparam logic [2:0] ST_CNT_WR = 3'd4;

   localparam logic [1:0] MODE_QUERY  = 2'd0;
   localparam logic [1:0] MODE_WR_DEL = 2'd1;
   localparam logic [1:0] MODE_WR_ADD = 2'd2;

   // Memories.
   logic [VIN_W-1:0] element_store_ff    [MAX_ELEMENTS];
   logic [CNT_W-1:0] occurrence_table_ff [VALUE_SPACE];
   logic [VIN_W-1:0] elem_rd_ff;
   logic [CNT_W-1:0] cnt_rd_ff;

   // Control and window state.
   logic [2:0]       state_ff,      state_in;
   logic [1:0]       mode_ff,       mode_in;
   logic [VAL_W-1:0] clear_addr_ff, clear_addr_in;
   logic [POS_W-1:0] wl_ff,         wl_in;
   logic [POS_W-1:0] wr_ff,         wr_in;
   logic             active_ff,     active_in;
   logic [CNT_W-1:0] distinct_ff,   distinct_in;
   logic             rsp_valid_ff,  rsp_valid_in;

   // Payload registers.
   logic [POS_W-1:0] ql_ff,       ql_in;
   logic [POS_W-1:0] qr_ff,       qr_in;
   logic [POS_W-1:0] wpos_ff,     wpos_in;
   logic [VIN_W-1:0] val_ff,      val_in;
   logic             add_ff,      add_in;
   logic             from_elem_ff, from_elem_in;
   logic [VAL_W-1:0] cnt_addr_ff, cnt_addr_in;
   rdc_pkg::rsp_type rsp_ff,      rsp_in;

   // Memory controls.
   logic                  elem_re, elem_we;
   logic [POS_W-1:0]      elem_ridx, elem_widx;
   logic [VIN_W-1:0]      elem_wdata;
   logic [IDX_W+POS_W-1:0] elem_raddr_wide, elem_waddr_wide;
   logic [IDX_W-1:0]      elem_raddr, elem_waddr;
   logic                  cnt_re, cnt_we;
   logic [VIN_W-1:0]      cnt_val;
   logic [VAL_W+VIN_W-1:0] cnt_raddr_wide;
   logic [VAL_W-1:0]      cnt_raddr, cnt_waddr;
   logic [CNT_W-1:0]      cnt_wdata;
   logic [CNT_W+rdc_pkg::COUNT_W-1:0] distinct_wide;
   logic                  in_window;

   assign elem_raddr_wide = {{IDX_W{1'b0}}, elem_ridx};
   assign elem_waddr_wide = {{IDX_W{1'b0}}, elem_widx};
   assign elem_raddr      = elem_raddr_wide[IDX_W-1:0];
   assign elem_waddr      = elem_waddr_wide[IDX_W-1:0];
   assign cnt_val         = from_elem_ff ? elem_rd_ff : val_ff;
   assign cnt_raddr_wide  = {{VAL_W{1'b0}}, cnt_val};
   assign cnt_raddr       = cnt_raddr_wide[VAL_W-1:0];
   assign distinct_wide   = {{rdc_pkg::COUNT_W{1'b0}}, distinct_ff};
   assign in_window       = active_ff && (head.position >= wl_ff) && (head.position <= wr_ff);

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      clear_addr_in = clear_addr_ff;
      wl_in         = wl_ff;
      wr_in         = wr_ff;
      active_in     = active_ff;
      distinct_in   = distinct_ff;
      rsp_valid_in  = 1'b0;
      ql_in         = ql_ff;
      qr_in         = qr_ff;
      wpos_in       = wpos_ff;
      val_in        = val_ff;
      add_in        = add_ff;
      from_elem_in  = from_elem_ff;
      cnt_addr_in   = cnt_addr_ff;
      rsp_in        = rsp_ff;
      pop           = 1'b0;
      elem_re       = 1'b0;
      elem_ridx     = '0;
      elem_we       = 1'b0;
      elem_widx     = wpos_ff;
      elem_wdata    = val_ff;
      cnt_re        = 1'b0;
      cnt_we        = 1'b0;
      cnt_waddr     = cnt_addr_ff;
      cnt_wdata     = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            cnt_we    = 1'b1;
            cnt_waddr = clear_addr_ff;
            if (clear_addr_ff == VAL_LAST) begin
               state_in = ST_IDLE;
            end else begin
               clear_addr_in = clear_addr_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (head_valid) begin
               pop = 1'b1;
               unique case (head.op)
                  rdc_pkg::OP_ERROR: begin
                     rsp_valid_in          = 1'b1;
                     rsp_in.distinct_count = '0;
                     rsp_in.range_error    = 1'b1;
                  end
                  rdc_pkg::OP_WRITE: begin
                     if (in_window) begin
                        // Take the old value out first, then add the new one.
                        elem_re      = 1'b1;
                        elem_ridx    = head.position;
                        add_in       = 1'b0;
                        from_elem_in = 1'b1;
                        mode_in      = MODE_WR_DEL;
                        val_in       = head.element_value;
                        wpos_in      = head.position;
                        state_in     = ST_CNT_RD;
                     end else begin
                        elem_we    = 1'b1;
                        elem_widx  = head.position;
                        elem_wdata = head.element_value;
                     end
                  end
                  rdc_pkg::OP_QUERY: begin
                     ql_in   = head.range_left;
                     qr_in   = head.range_right;
                     mode_in = MODE_QUERY;
                     if (!active_ff) begin
                        // Seed an empty window with its first element.
                        wl_in        = head.range_left;
                        wr_in        = head.range_left;
                        active_in    = 1'b1;
                        elem_re      = 1'b1;
                        elem_ridx    = head.range_left;
                        add_in       = 1'b1;
                        from_elem_in = 1'b1;
                        state_in     = ST_CNT_RD;
                     end else begin
                        state_in = ST_PLAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_PLAN: begin
            from_elem_in = 1'b1;
            if (wl_ff > ql_ff) begin
               wl_in     = wl_ff - 1'b1;
               elem_re   = 1'b1;
               elem_ridx = wl_ff - 1'b1;
               add_in    = 1'b1;
               state_in  = ST_CNT_RD;
            end else if (wr_ff < qr_ff) begin
               wr_in     = wr_ff + 1'b1;
               elem_re   = 1'b1;
               elem_ridx = wr_ff + 1'b1;
               add_in    = 1'b1;
               state_in  = ST_CNT_RD;
            end else if (wl_ff < ql_ff) begin
               wl_in     = wl_ff + 1'b1;
               elem_re   = 1'b1;
               elem_ridx = wl_ff;
               add_in    = 1'b0;
               state_in  = ST_CNT_RD;
            end else if (wr_ff > qr_ff) begin
               wr_in     = wr_ff - 1'b1;
               elem_re   = 1'b1;
               elem_ridx = wr_ff;
               add_in    = 1'b0;
               state_in  = ST_CNT_RD;
            end else begin
               rsp_valid_in          = 1'b1;
               rsp_in.distinct_count = distinct_wide[rdc_pkg::COUNT_W-1:0];
               rsp_in.range_error    = 1'b0;
               state_in              = ST_IDLE;
            end
         end

         ST_CNT_RD: begin
            cnt_re      = 1'b1;
            cnt_addr_in = cnt_raddr;
            state_in    = ST_CNT_WR;
         end

         ST_CNT_WR: begin
            if (add_ff) begin
               cnt_we    = 1'b1;
               cnt_wdata = cnt_rd_ff + 1'b1;
               if (cnt_rd_ff == '0) begin
                  distinct_in = distinct_ff + 1'b1;
               end
            end else if (cnt_rd_ff != '0) begin
               cnt_we    = 1'b1;
               cnt_wdata = cnt_rd_ff - 1'b1;
               if ((cnt_rd_ff == CNT_W'(1)) && (distinct_ff != '0)) begin
                  distinct_in = distinct_ff - 1'b1;
               end
            end
            unique case (mode_ff)
               MODE_QUERY: begin
                  state_in = ST_PLAN;
               end
               MODE_WR_DEL: begin
                  add_in       = 1'b1;
                  from_elem_in = 1'b0;
                  mode_in      = MODE_WR_ADD;
                  state_in     = ST_CNT_RD;
               end
               MODE_WR_ADD: begin
                  elem_we  = 1'b1;
                  state_in = ST_IDLE;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         mode_ff       <= MODE_QUERY;
         clear_addr_ff <= '0;
         wl_ff         <= '0;
         wr_ff         <= '0;
         active_ff     <= 1'b0;
         distinct_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         clear_addr_ff <= clear_addr_in;
         wl_ff         <= wl_in;
         wr_ff         <= wr_in;
         active_ff     <= active_in;
         distinct_ff   <= distinct_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ql_ff        <= ql_in;
      qr_ff        <= qr_in;
      wpos_ff      <= wpos_in;
      val_ff       <= val_in;
      add_ff       <= add_in;
      from_elem_ff <= from_elem_in;
      cnt_addr_ff  <= cnt_addr_in;
      rsp_ff       <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (elem_we) begin
         element_store_ff[elem_waddr] <= elem_wdata;
      end
      if (elem_re) begin
         elem_rd_ff <= element_store_ff[elem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         occurrence_table_ff[cnt_waddr] <= cnt_wdata;
      end
      if (cnt_re) begin
         cnt_rd_ff <= occurrence_table_ff[cnt_raddr];
      end
   end

   assign clearing  = (state_ff == ST_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

@@ design/range_distinct_count_core.sv @@
`default_nettype none
// Engine: a popped query goes to the plan state, which moves one edge element at a time through
// the counter read and write states until the window matches and the result is registered; a
// first query seeds the window and starts at counter read. A bad-range query is answered from
// idle. A write inside the window runs the counter states for the old value, then the new one;
// any other write is stored from idle. One entry at a time; busy rises while the two-entry queue
// is full. Reset is synchronous; then the occurrence counters are swept to zero, busy held high.

// Distinct-value counter over index ranges of an element array.
//
// The front end classifies each request transfer: writes that fall outside the
// element store or the value space are dropped, queries with a bad range become
// error entries, and everything else is queued as a write or a query. The short
// queue lets a new request transfer be taken while the back end is still walking
// the window for an earlier query.
//
// The back end keeps one sliding window with an occurrence counter per value and
// a running distinct count. For each query it first widens the window to cover
// the new range and only then narrows it, one element per step, so no counter
// ever goes below zero. A write that lands inside the window removes the old
// value from the window before the new one is added.
//
// Results are strobed on rsp_valid for a single cycle; the receiver cannot
// hold them off. Writes produce no response.
module range_distinct_count_core #(
   parameter int MAX_ELEMENTS = rdc_pkg::DEF_MAX_ELEMENTS,
   parameter int VALUE_SPACE  = rdc_pkg::DEF_VALUE_SPACE
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rdc_pkg::req_type req_data,
   output logic             rsp_valid,
   output rdc_pkg::rsp_type rsp_data
);

   rdc_pkg::entry_type  front_entry;
   logic                front_keep;
   logic                q_push;
   logic                q_pop;
   rdc_pkg::entry_type  q_head;
   rdc_pkg::q_stat_type q_stat;
   logic                back_clearing;

   // The block takes no request while the queue is full or the counters are
   // still being swept after reset.
   assign busy   = q_stat.full || back_clearing;
   assign q_push = start && !busy && front_keep;

   rdc_front #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .VALUE_SPACE  (VALUE_SPACE)
   ) u_front (
      .req   (req_data),
      .entry (front_entry),
      .keep  (front_keep)
   );

   rdc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (front_entry),
      .pop        (q_pop),
      .head       (q_head),
      .stat       (q_stat)
   );

   rdc_back #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .VALUE_SPACE  (VALUE_SPACE)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .head_valid (q_stat.valid),
      .pop        (q_pop),
      .clearing   (back_clearing),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

   // A queued transfer never overwrites a waiting entry.
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_stat.full)
      else $error("request pushed into a full queue");

   // The engine pops only entries that are present.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_stat.valid)
      else $error("pop from an empty queue");

   // No response can come out while the counters are still being swept.
   assert property (@(posedge clock) disable iff (reset) back_clearing |-> !rsp_valid)
      else $error("response during counter sweep");

   // An error response always carries a zero count.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.range_error) |-> (rsp_data.distinct_count == '0))
      else $error("error response with nonzero count");

endmodule

`default_nettype wire
